// ===== hw/rtl/chps_pkg.sv =====
// Shared types and constants of the Charlier polynomial sequence unit.
// Used by the top level, the iterative divider and the port checker.
`default_nettype none

package chps_pkg;

  localparam int X_W      = 24;
  localparam int MEAN_W   = 24;
  localparam int ORD_W    = 6;
  localparam int VAL_W    = 48;
  localparam int HALF_W   = 24;
  localparam int AMX_W    = MEAN_W + 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 24;

  localparam int DEF_MAX_ORDER = 63;
  localparam int DEF_FRAC_BITS = 16;

  localparam logic [MEAN_W-1:0] MEAN_RESET  = 24'd65536;
  localparam logic [ORD_W-1:0]  ORDER_RESET = 6'd7;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_POISSON_MEAN  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGHEST_ORDER = 1'b1;

  localparam logic [VAL_W-1:0] POS_LIMIT = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] NEG_LIMIT = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [VAL_W-1:0] value;
  } div_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/chps_div.sv =====
// Iterative restoring divider of a signed wide numerator by the unsigned mean,
// one quotient bit per cycle, with saturation to the 48-bit result range.
// Depends on chps_pkg.
`default_nettype none

module chps_div #(
  parameter int NUM_W = 76
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            start,
  input  wire signed [NUM_W-1:0]         num,
  input  wire [chps_pkg::MEAN_W-1:0]     den,
  output chps_pkg::div_res_t             res
);

  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int M_W   = chps_pkg::MEAN_W;
  localparam int V_W   = chps_pkg::VAL_W;

  logic             running;
  logic             finish;
  logic [CNT_W-1:0] count;
  logic             neg;
  logic             zero;
  logic [NUM_W-1:0] quot;
  logic [M_W-1:0]   rem;

  logic             q_done;
  logic             q_ovf;
  logic [V_W-1:0]   q_value;

  logic [M_W+1:0]   diff;
  logic             ge;
  logic             over;
  logic [V_W-1:0]   mag;

  assign diff = {1'b0, rem, quot[NUM_W-1]} - {2'b00, den};
  assign ge   = ~diff[M_W+1];

  assign res = '{done: q_done, ovf: q_ovf, value: q_value};

  // The negative range reaches one step further than the positive one.
  always_comb begin
    over = (quot[NUM_W-1:V_W-1] != '0) && !(neg && quot[NUM_W-1:V_W-1] == 1 &&
           quot[V_W-2:0] == '0);
    if (over) begin
      mag = neg ? chps_pkg::NEG_LIMIT : chps_pkg::POS_LIMIT;
    end else begin
      mag = quot[V_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      finish  <= 1'b0;
      count   <= '0;
      q_done  <= 1'b0;
    end else begin
      q_done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= CNT_W'(NUM_W);
      end else if (running) begin
        count <= count - 1'b1;
        if (count == 1) begin
          running <= 1'b0;
          finish  <= 1'b1;
        end
      end else if (finish) begin
        finish <= 1'b0;
        q_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= num[NUM_W-1];
      zero <= (num == '0);
      quot <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      rem  <= '0;
    end else if (running) begin
      quot <= {quot[NUM_W-2:0], ge};
      rem  <= ge ? diff[M_W-1:0] : {rem[M_W-2:0], quot[NUM_W-1]};
    end else if (finish) begin
      // A zero numerator gives zero even when the mean is zero.
      if (zero) begin
        q_value <= '0;
        q_ovf   <= 1'b0;
      end else begin
        q_value <= neg ? V_W'(-mag) : mag;
        q_ovf   <= over;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/charlier_polynomial_sequence_unit.sv =====
// Top level of the Charlier polynomial sequence unit: sequencer, shared
// multiplier and recurrence registers. Depends on chps_pkg and chps_div.
//
//  channel   ports                                                     handshake
//  input     start, x_value                                            start && !busy
//  result    result_strobe, order_index, poly_value, overflow_flag,    strobe, one cycle
//            last_of_run
//  config    cfg_write, cfg_index, cfg_data                            cfg_write
//
// One item gives N+1 results, N = min(highest_order, MAX_ORDER). Order 0 is shown in
// the cycle after the accept; order 1 is then computed by the divider alone, and every higher
// order by S_PREP, S_MUL and the divider in turn (NUM_W = 76 at 16 fraction bits).
// The one-bit-a-cycle divider works through all NUM_W numerator bits; S_PREP prepares the
// operands, and the 27x24 multiplier then forms four partial products in S_MUL.
// Reset is synchronous; results cannot be held off, and busy stays high until
// the last result has been shown.
`default_nettype none

module charlier_polynomial_sequence_unit #(
  parameter int MAX_ORDER = chps_pkg::DEF_MAX_ORDER,
  parameter int FRAC_BITS = chps_pkg::DEF_FRAC_BITS
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  start,
  output logic                                 busy,
  input  wire signed [chps_pkg::X_W-1:0]       x_value,
  input  wire                                  cfg_write,
  input  wire [chps_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [chps_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                 result_strobe,
  output logic [chps_pkg::ORD_W-1:0]           order_index,
  output logic signed [chps_pkg::VAL_W-1:0]    poly_value,
  output logic                                 overflow_flag,
  output logic                                 last_of_run
);

  localparam int ORD_W  = chps_pkg::ORD_W;
  localparam int VAL_W  = chps_pkg::VAL_W;
  localparam int HALF_W = chps_pkg::HALF_W;
  localparam int AMX_W  = chps_pkg::AMX_W;
  localparam int KW     = ORD_W + FRAC_BITS;
  localparam int A_W    = (KW > AMX_W ? KW : AMX_W) + 1;
  localparam int PW     = A_W + HALF_W;
  localparam int NW     = A_W + 2 * HALF_W + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EMIT = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;

  logic [2:0]                    state;
  logic [chps_pkg::MEAN_W-1:0]   poisson_mean;
  logic [ORD_W-1:0]              highest_order;

  logic [ORD_W-1:0]              order_counter;
  logic [ORD_W-1:0]              top;
  logic signed [chps_pkg::X_W-1:0] held_x;
  logic signed [AMX_W-1:0]       amx;
  logic signed [VAL_W-1:0]       prev_value;
  logic signed [VAL_W-1:0]       curr_value;
  logic                          sticky_overflow;

  logic [A_W-1:0]                opa_mag;
  logic                          opa_neg;
  logic [VAL_W-1:0]              curr_mag;
  logic [VAL_W-1:0]              prev_mag;
  logic [2:0]                    step;
  logic [PW-1:0]                 prod;
  logic                          prod_neg;
  logic                          prod_hi;
  logic signed [NW-1:0]          acc;

  logic                          div_start;
  logic signed [NW-1:0]          div_num;
  chps_pkg::div_res_t            div_res;

  logic [KW-1:0]                 kf;
  logic signed [A_W-1:0]         opa_sum;
  logic [A_W-1:0]                mul_a;
  logic [VAL_W-1:0]              mul_bsrc;
  logic [HALF_W-1:0]             mul_b;
  logic [NW-1:0]                 shifted;
  logic signed [NW-1:0]          acc_next;
  logic [ORD_W-1:0]              top_next;

  chps_div #(
    .NUM_W (NW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (poisson_mean),
    .res   (div_res)
  );

  assign busy          = (state != S_IDLE);
  assign result_strobe = (state == S_EMIT);
  assign order_index   = order_counter;
  assign poly_value    = curr_value;
  assign overflow_flag = sticky_overflow;
  assign last_of_run   = (order_counter == top);

  assign top_next = (highest_order > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : highest_order;

  // order_counter already holds the new order k+1 here, so k = order_counter - 1.
  assign kf      = {order_counter - 1'b1, {FRAC_BITS{1'b0}}};
  assign opa_sum = {{(A_W-AMX_W){amx[AMX_W-1]}}, amx} + {{(A_W-KW){1'b0}}, kf};

  // Partial product order: A*curr low, A*curr high, k*prev low, k*prev high.
  always_comb begin
    mul_a    = step[2] ? {{(A_W-KW){1'b0}}, kf} : opa_mag;
    mul_bsrc = step[2] ? prev_mag : curr_mag;
    mul_b    = step[1] ? mul_bsrc[VAL_W-1:HALF_W] : mul_bsrc[HALF_W-1:0];
    shifted  = prod_hi ? {{(NW-PW-HALF_W){1'b0}}, prod, {HALF_W{1'b0}}}
                       : {{(NW-PW){1'b0}}, prod};
    acc_next = acc + (prod_neg ? -$signed(shifted) : $signed(shifted));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poisson_mean  <= chps_pkg::MEAN_RESET;
      highest_order <= chps_pkg::ORDER_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        chps_pkg::REG_POISSON_MEAN:  poisson_mean  <= cfg_data[chps_pkg::MEAN_W-1:0];
        chps_pkg::REG_HIGHEST_ORDER: highest_order <= cfg_data[ORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      div_start       <= 1'b0;
      order_counter   <= '0;
      top             <= '0;
      sticky_overflow <= 1'b0;
      held_x          <= '0;
      prev_value      <= '0;
      curr_value      <= '0;
      step            <= '0;
    end else begin
      div_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            held_x          <= x_value;
            amx             <= $signed({2'b00, poisson_mean}) - AMX_W'(x_value);
            top             <= top_next;
            order_counter   <= '0;
            prev_value      <= '0;
            curr_value      <= VAL_W'(1) << FRAC_BITS;
            sticky_overflow <= 1'b0;
            state           <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (order_counter == top) begin
            state <= S_IDLE;
          end else begin
            order_counter <= order_counter + 1'b1;
            if (order_counter == '0) begin
              div_num   <= NW'(amx) <<< FRAC_BITS;
              div_start <= 1'b1;
              state     <= S_DIV;
            end else begin
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          opa_neg  <= opa_sum[A_W-1];
          opa_mag  <= opa_sum[A_W-1] ? A_W'(-opa_sum) : A_W'(opa_sum);
          curr_mag <= curr_value[VAL_W-1] ? VAL_W'(-curr_value) : VAL_W'(curr_value);
          prev_mag <= prev_value[VAL_W-1] ? VAL_W'(-prev_value) : VAL_W'(prev_value);
          acc      <= '0;
          step     <= '0;
          state    <= S_MUL;
        end
        S_MUL: begin
          step <= step + 1'b1;
          if (!step[0]) begin
            prod    <= PW'(mul_a) * PW'(mul_b);
            prod_hi <= step[1];
            // The k*prev term is subtracted; k itself is never negative.
            prod_neg <= step[2] ? ~prev_value[VAL_W-1] : (opa_neg ^ curr_value[VAL_W-1]);
          end else begin
            acc <= acc_next;
            if (step == 3'd7) begin
              div_num   <= acc_next;
              div_start <= 1'b1;
              state     <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            prev_value      <= curr_value;
            curr_value      <= div_res.value;
            sticky_overflow <= sticky_overflow | div_res.ovf;
            state           <= S_EMIT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/chps_checker.sv =====
// Port-level checks of the Charlier polynomial sequence unit, bound to the
// top level. Depends on chps_pkg for field widths.
`default_nettype none

module chps_checker (
  input wire                           clk,
  input wire                           rst,
  input wire                           start,
  input wire                           busy,
  input wire                           result_strobe,
  input wire [chps_pkg::ORD_W-1:0]     order_index,
  input wire                           last_of_run
);

  // The first result of a run follows the accepted transfer directly.
  a_first_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> result_strobe && order_index == 0)
    else $error("first result did not follow the accepted item");

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> busy)
    else $error("result shown while idle");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    result_strobe && last_of_run |=> !busy && !result_strobe)
    else $error("unit still busy after the last result");

  a_results_apart: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last_of_run |=> busy && !result_strobe)
    else $error("results of a run not separated by the recurrence step");

endmodule

bind charlier_polynomial_sequence_unit chps_checker u_chps_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .result_strobe (result_strobe),
  .order_index   (order_index),
  .last_of_run   (last_of_run)
);

`default_nettype wire
